// ===== hw/rtl/hrq_pkg.sv =====
// ----------------------------------------------------------------------------
// hrq_pkg
// Shared types and codes of the handle ring queue.
// ----------------------------------------------------------------------------
package hrq_pkg;

    localparam int CMD_W          = 3;
    localparam int HANDLE_FIELD_W = 16;
    localparam int STATUS_W       = 2;
    localparam int CNT_W          = 5;
    localparam int CAP_RESET      = 16;
    localparam int CAP_LIMIT      = 31;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [HANDLE_FIELD_W-1:0] handle;
    } hrq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [HANDLE_FIELD_W-1:0] out_handle;
        logic [CNT_W-1:0]          fill_level;
        logic [CNT_W-1:0]          free_slots;
        logic                      last;
    } hrq_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FLUSH
    } hrq_state_t;

endpackage

// ===== hw/rtl/hrq_ram.sv =====
// ----------------------------------------------------------------------------
// hrq_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrq_ram #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [HANDLE_WIDTH-1:0]  wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [HANDLE_WIDTH-1:0]  rdata
);

    logic [HANDLE_WIDTH-1:0] mem [DEPTH];
    logic [HANDLE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrq_ctrl
// Command sequencer: ring pointers, entry count and slot store access.
// ----------------------------------------------------------------------------
module hrq_ctrl #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [hrq_pkg::CNT_W-1:0]    cap,
    input  logic                         clear,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  hrq_pkg::hrq_req_t            req,
    input  logic                         slot_free,
    output logic                         rsp_load,
    output hrq_pkg::hrq_rsp_t            rsp_beat,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_waddr,
    output logic [HANDLE_WIDTH-1:0]      ram_wdata,
    output logic                         ram_re,
    output logic [$clog2(DEPTH)-1:0]     ram_raddr,
    input  logic [HANDLE_WIDTH-1:0]      ram_rdata
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WRAP_W = (IDX_W + 1 > hrq_pkg::CNT_W) ? IDX_W + 1 : hrq_pkg::CNT_W;

    hrq_pkg::hrq_state_t state_reg, state_next;
    logic [IDX_W-1:0]            rd_reg, rd_next;
    logic [IDX_W-1:0]            wr_reg, wr_next;
    logic [hrq_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic [IDX_W-1:0]            rd_inc, rd_dec, wr_inc;
    logic [HANDLE_WIDTH-1:0]     hval;
    logic                        empty, full;
    logic [hrq_pkg::CNT_W-1:0]   fill;

    assign rd_inc = (WRAP_W'(rd_reg) + WRAP_W'(1) == WRAP_W'(cap)) ? '0 : rd_reg + IDX_W'(1);
    assign wr_inc = (WRAP_W'(wr_reg) + WRAP_W'(1) == WRAP_W'(cap)) ? '0 : wr_reg + IDX_W'(1);
    assign rd_dec = (rd_reg == '0) ? IDX_W'(WRAP_W'(cap) - WRAP_W'(1)) : rd_reg - IDX_W'(1);
    assign hval   = HANDLE_WIDTH'(req.handle);
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg >= cap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrq_pkg::S_IDLE;
            rd_reg    <= '0;
            wr_reg    <= '0;
            cnt_reg   <= '0;
        end
        else if (clear)
        begin
            state_reg <= hrq_pkg::S_IDLE;
            rd_reg    <= '0;
            wr_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = wr_reg;
        ram_wdata  = hval;
        ram_re     = 1'b0;
        ram_raddr  = rd_reg;
        rsp_load   = 1'b0;
        fill       = cnt_reg;
        req_ready  = (state_reg == hrq_pkg::S_IDLE) && slot_free;

        rsp_beat.status     = hrq_pkg::STAT_OK;
        rsp_beat.out_handle = '0;
        rsp_beat.last       = 1'b1;

        unique case (state_reg)
            hrq_pkg::S_IDLE:
            begin
                if (req_valid && slot_free)
                begin
                    unique case (req.command)
                        hrq_pkg::CMD_PUSH_BACK, hrq_pkg::CMD_PUSH_FRONT:
                        begin
                            priority if (hval == '0)
                            begin
                                rsp_load        = 1'b1;
                                rsp_beat.status = hrq_pkg::STAT_NULL;
                            end
                            else if (full)
                            begin
                                rsp_load        = 1'b1;
                                rsp_beat.status = hrq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                rsp_load = 1'b1;
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + hrq_pkg::CNT_W'(1);
                                if (req.command == hrq_pkg::CMD_PUSH_BACK)
                                begin
                                    ram_waddr = wr_reg;
                                    wr_next   = wr_inc;
                                end
                                else
                                begin
                                    ram_waddr = rd_dec;
                                    rd_next   = rd_dec;
                                end
                            end
                        end
                        hrq_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                rsp_load        = 1'b1;
                                rsp_beat.status = hrq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rd_next    = rd_inc;
                                cnt_next   = cnt_reg - hrq_pkg::CNT_W'(1);
                                state_next = hrq_pkg::S_READ;
                            end
                        end
                        hrq_pkg::CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                rsp_load        = 1'b1;
                                rsp_beat.status = hrq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = hrq_pkg::S_READ;
                            end
                        end
                        hrq_pkg::CMD_FLUSH:
                        begin
                            if (empty)
                            begin
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rd_next    = rd_inc;
                                cnt_next   = cnt_reg - hrq_pkg::CNT_W'(1);
                                state_next = hrq_pkg::S_FLUSH;
                            end
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
                fill = cnt_next;
            end
            hrq_pkg::S_READ:
            begin
                if (slot_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_beat.out_handle = hrq_pkg::HANDLE_FIELD_W'(ram_rdata);
                    state_next          = hrq_pkg::S_IDLE;
                end
            end
            hrq_pkg::S_FLUSH:
            begin
                if (slot_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_beat.out_handle = hrq_pkg::HANDLE_FIELD_W'(ram_rdata);
                    rsp_beat.last       = empty;
                    if (empty)
                    begin
                        state_next = hrq_pkg::S_IDLE;
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        rd_next  = rd_inc;
                        cnt_next = cnt_reg - hrq_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = hrq_pkg::S_IDLE;
            end
        endcase

        rsp_beat.fill_level = fill;
        rsp_beat.free_slots = cap - fill;
    end

    // The count never exceeds the capacity in use.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cap)
        else $error("entry count above capacity");

    // A slot is never written and read in the same cycle.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("write and read of the slot store overlap");

    // Every slot read leaves the sequencer waiting on its data.
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && !clear) |=> (state_reg != hrq_pkg::S_IDLE))
        else $error("slot read issued without a data state");

    // A single read finishes with exactly one beat and returns to idle.
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrq_pkg::S_READ && slot_free && !clear)
        |-> rsp_load ##1 (state_reg == hrq_pkg::S_IDLE))
        else $error("pop or peek did not complete");

    // While draining, at least one entry has already left the queue.
    a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrq_pkg::S_FLUSH) |-> (cnt_reg < cap))
        else $error("flush running on a full queue");

endmodule

// ===== hw/rtl/handle_ring_queue_with_front_insert_unit.sv =====
// ----------------------------------------------------------------------------
// handle_ring_queue_with_front_insert_unit
// Ring queue of buffer handles with push back, push front, pop, peek, flush.
// ----------------------------------------------------------------------------
// Commands enter on the req channel and results leave on the rsp channel,
// both valid/ready; a beat moves when valid and ready are high together.
// The cfg channel writes the queue capacity (clamped to 1..DEPTH, at most
// 31) and empties the queue; the user must write it only while the queue
// is idle, which the block does not enforce. Pushes, errors and unknown
// commands give their beat in the cycle after acceptance and a new command
// can be taken every cycle while the rsp side keeps up. Pop and peek take
// no new command while the slot store read port fetches their handle.
// A flush of n entries gives n beats, the last one marked; a flush of an
// empty queue gives one marked beat with handle 0. A single result
// register sits on the rsp side; while it is full and not taken, no
// command is accepted and a flush pauses. Reset empties the queue and sets
// the capacity to 16 (or DEPTH if smaller); the slot store is not cleared.
// ----------------------------------------------------------------------------
module handle_ring_queue_with_front_insert_unit #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  hrq_pkg::hrq_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output hrq_pkg::hrq_rsp_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [hrq_pkg::CNT_W-1:0] cfg_data
);

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CAP_MAX  = (DEPTH > hrq_pkg::CAP_LIMIT) ? hrq_pkg::CAP_LIMIT : DEPTH;
    localparam int CAP_INIT = (hrq_pkg::CAP_RESET > CAP_MAX) ? CAP_MAX : hrq_pkg::CAP_RESET;

    logic [hrq_pkg::CNT_W-1:0] cap_reg, cap_next;
    logic                      cfg_write;
    logic                      rsp_valid_reg;
    hrq_pkg::hrq_rsp_t         rsp_reg;
    logic                      slot_free;
    logic                      rsp_load;
    hrq_pkg::hrq_rsp_t         rsp_beat;

    logic                      ram_we, ram_re;
    logic [IDX_W-1:0]          ram_waddr, ram_raddr;
    logic [HANDLE_WIDTH-1:0]   ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cap_next = hrq_pkg::CNT_W'(1);
        end
        else if (int'(cfg_data) > CAP_MAX)
        begin
            cap_next = hrq_pkg::CNT_W'(CAP_MAX);
        end
        else
        begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= hrq_pkg::CNT_W'(CAP_INIT);
        end
        else if (cfg_write)
        begin
            cap_reg <= cap_next;
        end
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_beat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    hrq_ctrl #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .clear     (cfg_write),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .slot_free (slot_free),
        .rsp_load  (rsp_load),
        .rsp_beat  (rsp_beat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    hrq_ram #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== bench/hrq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrq_checker
// Watches the ports of the handle ring queue, predicts every result beat and
// compares it with what the block sends.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the ring: slots, read and write pointers,
// entry count and capacity. Each accepted command adds its expected beats to
// a queue. Each accepted result beat is compared field by field with the
// oldest expected beat. A capacity write clamps the value and empties the
// ring. The number of beats still owed and the failure count go to the top.
// ----------------------------------------------------------------------------
module hrq_checker
    import hrq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int MAX_REPORTS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  hrq_req_t          req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  hrq_rsp_t          rsp,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    output int                fail_count,
    output int                beats_pending
);

    logic [HANDLE_FIELD_W-1:0] slots [DEPTH];
    int                        wr_ptr;
    int                        rd_ptr;
    int                        held;
    int                        capacity;
    int                        mismatches = 0;
    hrq_rsp_t                  owed_beats [$];
    hrq_rsp_t                  want;
    logic [HANDLE_FIELD_W-1:0] drained;

    function automatic logic [HANDLE_FIELD_W-1:0] take_oldest();
        logic [HANDLE_FIELD_W-1:0] value;
        value  = slots[rd_ptr];
        rd_ptr = (rd_ptr + 1) % capacity;
        held   = held - 1;
        return value;
    endfunction

    function automatic void owe_beat(input logic [STATUS_W-1:0] status,
                                     input logic [HANDLE_FIELD_W-1:0] value,
                                     input logic last);
        hrq_rsp_t beat;
        beat.status     = status;
        beat.out_handle = value;
        beat.fill_level = CNT_W'(held);
        beat.free_slots = CNT_W'(capacity - held);
        beat.last       = last;
        owed_beats.push_back(beat);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr   = 0;
            rd_ptr   = 0;
            held     = 0;
            capacity = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
            owed_beats.delete();
            beats_pending <= 0;
            fail_count    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data == '0)
                    capacity = 1;
                else if (int'(cfg_data) > DEPTH)
                    capacity = DEPTH;
                else
                    capacity = int'(cfg_data);
                wr_ptr = 0;
                rd_ptr = 0;
                held   = 0;
            end

            if (req_valid && req_ready)
            begin
                case (req.command)
                    CMD_PUSH_BACK, CMD_PUSH_FRONT:
                    begin
                        if (req.handle == '0)
                            owe_beat(STAT_NULL, '0, 1'b1);
                        else if (held >= capacity)
                            owe_beat(STAT_FULL, '0, 1'b1);
                        else
                        begin
                            if (req.command == CMD_PUSH_BACK)
                            begin
                                slots[wr_ptr] = req.handle;
                                wr_ptr = (wr_ptr + 1) % capacity;
                            end
                            else
                            begin
                                rd_ptr = (rd_ptr == 0) ? capacity - 1 : rd_ptr - 1;
                                slots[rd_ptr] = req.handle;
                            end
                            held = held + 1;
                            owe_beat(STAT_OK, '0, 1'b1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (held == 0)
                            owe_beat(STAT_EMPTY, '0, 1'b1);
                        else
                        begin
                            drained = take_oldest();
                            owe_beat(STAT_OK, drained, 1'b1);
                        end
                    end
                    CMD_PEEK:
                    begin
                        if (held == 0)
                            owe_beat(STAT_EMPTY, '0, 1'b1);
                        else
                            owe_beat(STAT_OK, slots[rd_ptr], 1'b1);
                    end
                    CMD_FLUSH:
                    begin
                        if (held == 0)
                            owe_beat(STAT_OK, '0, 1'b1);
                        while (held > 0)
                        begin
                            drained = take_oldest();
                            owe_beat(STAT_OK, drained, held == 0);
                        end
                    end
                    default:
                        owe_beat(STAT_OK, '0, 1'b1);
                endcase
            end

            if (rsp_valid && rsp_ready)
            begin
                if (owed_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("hrq_checker: %0t: result beat with none expected: %h",
                                 $time, rsp);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (rsp.status !== want.status || rsp.out_handle !== want.out_handle
                        || rsp.fill_level !== want.fill_level
                        || rsp.free_slots !== want.free_slots || rsp.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $write("hrq_checker: %0t: mismatch: expected status %0d ",
                                   $time, want.status);
                            $write("handle %h fill %0d free %0d last %b, ",
                                   want.out_handle, want.fill_level, want.free_slots,
                                   want.last);
                            $display("got status %0d handle %h fill %0d free %0d last %b",
                                     rsp.status, rsp.out_handle, rsp.fill_level,
                                     rsp.free_slots, rsp.last);
                        end
                    end
                end
            end

            beats_pending <= owed_beats.size();
            fail_count    <= mismatches;
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the handle ring queue with front insert.
// ----------------------------------------------------------------------------
// A directed run covers empty pops, peeks and flushes, null and full pushes,
// front inserts that wrap, undefined commands and capacity clamping. Random
// phases follow, each after a capacity write made while the queue is idle.
// Sender and receiver stall at random in three idling modes, and the
// receiver holds off for a long stretch twice so that the block backs up.
// The checker instance predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

    import hrq_pkg::*;

    localparam int DEPTH            = 16;
    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 5;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 80;
    localparam int RANDOM_PER_PHASE = 62;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid;
    logic              req_ready;
    hrq_req_t          req;
    logic              rsp_valid;
    logic              rsp_ready;
    hrq_rsp_t          rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    int fail_count;
    int beats_pending;
    int send_idle_pct = 7;
    int recv_idle_pct = 62;
    int random_sent   = 0;
    int cycle_count   = 0;
    bit hold_request  = 1'b0;

    always #CLK_HALF clk = ~clk;

    handle_ring_queue_with_front_insert_unit #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_FIELD_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hrq_checker #(
        .DEPTH (DEPTH)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    function automatic hrq_req_t command(input logic [CMD_W-1:0] code,
                                         input logic [HANDLE_FIELD_W-1:0] value);
        hrq_req_t item;
        item.command = code;
        item.handle  = value;
        return item;
    endfunction

    function automatic hrq_req_t random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            return command(CMD_PUSH_BACK, HANDLE_FIELD_W'($urandom_range(65535, 1)));
        else if (pick < 55)
            return command(CMD_PUSH_FRONT, HANDLE_FIELD_W'($urandom_range(65535, 1)));
        else if (pick < 72)
            return command(CMD_POP, HANDLE_FIELD_W'($urandom));
        else if (pick < 82)
            return command(CMD_PEEK, HANDLE_FIELD_W'($urandom));
        else if (pick < 88)
            return command(CMD_FLUSH, HANDLE_FIELD_W'($urandom));
        else if (pick < 94)
            return command(pick[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, '0);
        else
            return command(CMD_W'($urandom_range(CMD_RSVD_7, CMD_RSVD_5)),
                           HANDLE_FIELD_W'($urandom));
    endfunction

    task automatic offer(input hrq_req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase();
        repeat (RANDOM_PER_PHASE)
        begin
            if (random_sent < 170)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 62;
            end
            else if (random_sent < 340)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (random_sent == 40 || random_sent == 420)
                hold_request = 1'b1;
            offer(random_command());
            random_sent++;
        end
    endtask

    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    rsp_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        offer(command(CMD_PEEK, 16'h0000));
        offer(command(CMD_POP, 16'hFFFF));
        offer(command(CMD_FLUSH, 16'h0000));
        offer(command(CMD_PUSH_BACK, 16'h0000));
        offer(command(CMD_PUSH_FRONT, 16'h0000));
        offer(command(CMD_PUSH_FRONT, 16'h0001));
        offer(command(CMD_PUSH_BACK, 16'hFFFF));
        offer(command(CMD_PUSH_FRONT, 16'h8000));
        offer(command(CMD_PEEK, 16'h5A5A));
        offer(command(CMD_RSVD_5, 16'h0000));
        offer(command(CMD_RSVD_6, 16'hAAAA));
        offer(command(CMD_RSVD_7, 16'hFFFF));
        offer(command(CMD_POP, 16'h0000));
        offer(command(CMD_FLUSH, 16'h5555));

        set_capacity(5'd2);
        offer(command(CMD_PUSH_BACK, 16'h1234));
        offer(command(CMD_PUSH_BACK, 16'h5555));
        offer(command(CMD_PUSH_BACK, 16'h7777));
        offer(command(CMD_PUSH_FRONT, 16'h4321));
        offer(command(CMD_POP, 16'h0000));
        offer(command(CMD_PUSH_FRONT, 16'h00FF));
        offer(command(CMD_FLUSH, 16'h0000));

        set_capacity(5'd0);
        run_random_phase();
        set_capacity(5'd31);
        run_random_phase();
        set_capacity(5'd5);
        run_random_phase();
        set_capacity(5'd16);
        run_random_phase();
        set_capacity(5'd1);
        run_random_phase();
        set_capacity(5'd17);
        run_random_phase();
        set_capacity(5'd9);
        run_random_phase();
        set_capacity(5'd3);
        run_random_phase();

        wait_until_drained();
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== handle_ring_queue_with_front_insert_unit.f =====
hw/rtl/hrq_pkg.sv
hw/rtl/hrq_ram.sv
hw/rtl/hrq_ctrl.sv
hw/rtl/handle_ring_queue_with_front_insert_unit.sv
bench/hrq_checker.sv
bench/tb.sv
